@@ hdl/rgbapm_pkg.sv @@
// Shared types, register codes and pixel arithmetic for the RGBA premultiply converter.
package rgbapm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] REG_HAS_ALPHA     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BIG_ENDIAN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_STRIDE    = 3'd4;

   localparam int WIDTH_REG_W  = 13;
   localparam int HEIGHT_REG_W = 13;
   localparam int STRIDE_REG_W = 15;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd1;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;
   localparam logic [STRIDE_REG_W-1:0] STRIDE_RESET = 15'd4;

   localparam logic [15:0] ROUND_BIAS = 16'h007f;

   localparam int JOB_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   // One gathered pixel on its way from the front end to the arithmetic.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       alpha_en;
      logic       big_endian;
      logic       row_end;
      logic       image_end;
   } job_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        row_end;
      logic        image_end;
   } result_type;

   // Second half of the rounded divide by 255: ((t >> 8) + t) >> 8, low byte.
   function automatic logic [7:0] premul_finish(input logic [15:0] t);
      logic [16:0] sum;
      sum = 17'(t[15:8]) + 17'(t);
      return sum[15:8];
   endfunction

   function automatic logic [31:0] pack_word(input logic [7:0] red,
                                             input logic [7:0] green,
                                             input logic [7:0] blue,
                                             input logic [7:0] alpha,
                                             input logic       big_endian);
      return big_endian ? {blue, green, red, alpha} : {alpha, red, green, blue};
   endfunction

endpackage

@@ hdl/rgbapm_fifo.sv @@
// Small register-based FIFO used between the pipeline parts.
module rgbapm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = entries_ff[rd_ptr_ff];

   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hdl/rgbapm_front.sv @@
// Front end: configuration registers, stride walking and pixel byte gathering.
module rgbapm_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_STRIDE = 16384
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rgbapm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbapm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              in_accept,
   input  logic [7:0]                        in_byte,
   output logic                              job_valid,
   output rgbapm_pkg::job_type               job
);

   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int SPAN = (MAX_STRIDE > 4 * MAX_WIDTH) ? MAX_STRIDE : 4 * MAX_WIDTH;
   localparam int CW   = $clog2(SPAN + 1);

   logic                                 has_alpha_ff;
   logic                                 big_endian_ff;
   logic [rgbapm_pkg::WIDTH_REG_W-1:0]   image_width_ff;
   logic [rgbapm_pkg::HEIGHT_REG_W-1:0]  image_height_ff;
   logic [rgbapm_pkg::STRIDE_REG_W-1:0]  row_stride_ff;

   logic [7:0]    held_ff [3];
   logic [1:0]    chan_pos_ff, chan_pos_in;
   logic [CW-1:0] row_byte_ff, row_byte_in;
   logic [HW-1:0] row_count_ff, row_count_in;

   logic [WW-1:0] width_c;
   logic [HW-1:0] height_c;
   logic [CW-1:0] stride_c, pix_bytes, row_len;
   logic [CW:0]   row_byte_inc;
   logic          last_row, in_pixels, pixel_done, row_done, end_of_row;

   // Effective geometry after clamping the register values.
   always_comb begin
      if (image_width_ff == '0) begin
         width_c = WW'(1);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_c = WW'(MAX_WIDTH);
      end else begin
         width_c = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_c = HW'(1);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         height_c = HW'(MAX_HEIGHT);
      end else begin
         height_c = HW'(image_height_ff);
      end
      stride_c  = (32'(row_stride_ff) > 32'(MAX_STRIDE)) ? CW'(MAX_STRIDE)
                                                         : CW'(row_stride_ff);
      pix_bytes = has_alpha_ff ? (CW'(width_c) << 2)
                               : ((CW'(width_c) << 1) + CW'(width_c));
      row_len   = (stride_c < pix_bytes) ? pix_bytes : stride_c;
   end

   assign row_byte_inc = (CW+1)'(row_byte_ff) + (CW+1)'(1);
   assign last_row     = ((HW+1)'(row_count_ff) + (HW+1)'(1)) >= (HW+1)'(height_c);
   assign in_pixels    = row_byte_ff < pix_bytes;
   assign pixel_done   = (has_alpha_ff ? (chan_pos_ff == 2'd3) : (chan_pos_ff >= 2'd2));
   assign row_done     = row_byte_inc >= (CW+1)'(pix_bytes);
   assign end_of_row   = last_row ? row_done : (row_byte_inc >= (CW+1)'(row_len));

   assign job_valid = in_accept && in_pixels && pixel_done;

   always_comb begin
      job.red        = held_ff[0];
      job.green      = held_ff[1];
      job.blue       = has_alpha_ff ? held_ff[2] : in_byte;
      job.alpha      = has_alpha_ff ? in_byte : 8'h00;
      job.alpha_en   = has_alpha_ff;
      job.big_endian = big_endian_ff;
      job.row_end    = row_done;
      job.image_end  = row_done && last_row;
   end

   always_comb begin
      chan_pos_in  = chan_pos_ff;
      row_byte_in  = row_byte_ff;
      row_count_in = row_count_ff;
      if (in_accept) begin
         if (in_pixels) begin
            chan_pos_in = pixel_done ? 2'd0 : chan_pos_ff + 2'd1;
         end
         if (end_of_row) begin
            row_byte_in  = '0;
            chan_pos_in  = 2'd0;
            row_count_in = last_row ? '0 : row_count_ff + HW'(1);
         end else begin
            row_byte_in = row_byte_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff    <= 1'b0;
         big_endian_ff   <= 1'b0;
         image_width_ff  <= rgbapm_pkg::WIDTH_RESET;
         image_height_ff <= rgbapm_pkg::HEIGHT_RESET;
         row_stride_ff   <= rgbapm_pkg::STRIDE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rgbapm_pkg::REG_HAS_ALPHA:    has_alpha_ff    <= csr_wdata[0];
            rgbapm_pkg::REG_BIG_ENDIAN:   big_endian_ff   <= csr_wdata[0];
            rgbapm_pkg::REG_IMAGE_WIDTH:
               image_width_ff  <= csr_wdata[rgbapm_pkg::WIDTH_REG_W-1:0];
            rgbapm_pkg::REG_IMAGE_HEIGHT:
               image_height_ff <= csr_wdata[rgbapm_pkg::HEIGHT_REG_W-1:0];
            rgbapm_pkg::REG_ROW_STRIDE:
               row_stride_ff   <= csr_wdata[rgbapm_pkg::STRIDE_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff  <= 2'd0;
         row_byte_ff  <= '0;
         row_count_ff <= '0;
         held_ff[0]   <= 8'h00;
         held_ff[1]   <= 8'h00;
         held_ff[2]   <= 8'h00;
      end else begin
         chan_pos_ff  <= chan_pos_in;
         row_byte_ff  <= row_byte_in;
         row_count_ff <= row_count_in;
         if (in_accept && in_pixels && !pixel_done && chan_pos_ff != 2'd3) begin
            held_ff[chan_pos_ff] <= in_byte;
         end
      end
   end

endmodule

@@ hdl/rgbapm_back.sv @@
// Back end: premultiply pipeline, word packing and the result queue.
module rgbapm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_empty,
   input  rgbapm_pkg::job_type  job,
   output logic                 job_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [31:0]          rsp_pixel_word,
   output logic                 rsp_row_end,
   output logic                 rsp_image_end
);

   localparam int QCW = $clog2(rgbapm_pkg::OUT_DEPTH + 1);

   logic [15:0] t_ff [3];
   logic [15:0] t_in [3];
   logic [7:0]  color [3];
   logic [7:0]  alpha_ff;
   logic        alpha_en_ff, big_endian_ff, row_end_ff, image_end_ff;
   logic        s1_valid_ff;
   logic [7:0]  done_ch [3];

   logic [QCW-1:0]          outq_count;
   logic                    outq_full;
   rgbapm_pkg::result_type  outq_wr, outq_rd;

   // Issue only when the result queue has room for everything in flight.
   assign job_pop = !job_empty &&
                    (((QCW+1)'(outq_count) + (QCW+1)'(s1_valid_ff))
                     < (QCW+1)'(rgbapm_pkg::OUT_DEPTH));

   assign color[0] = job.red;
   assign color[1] = job.green;
   assign color[2] = job.blue;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = job.alpha_en ? (16'(color[i]) * 16'(job.alpha) + rgbapm_pkg::ROUND_BIAS)
                                : {color[i], 8'h00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= job_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         t_ff[0]       <= t_in[0];
         t_ff[1]       <= t_in[1];
         t_ff[2]       <= t_in[2];
         alpha_ff      <= job.alpha;
         alpha_en_ff   <= job.alpha_en;
         big_endian_ff <= job.big_endian;
         row_end_ff    <= job.row_end;
         image_end_ff  <= job.image_end;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         done_ch[i] = alpha_en_ff ? rgbapm_pkg::premul_finish(t_ff[i]) : t_ff[i][15:8];
      end
      outq_wr.pixel_word = rgbapm_pkg::pack_word(done_ch[0], done_ch[1], done_ch[2],
                                                 alpha_ff, big_endian_ff);
      outq_wr.row_end    = row_end_ff;
      outq_wr.image_end  = image_end_ff;
   end

   rgbapm_fifo #(
      .WIDTH ($bits(rgbapm_pkg::result_type)),
      .DEPTH (rgbapm_pkg::OUT_DEPTH)
   ) u_outq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_valid_ff),
      .wr_data (outq_wr),
      .rd_en   (rsp_pop),
      .rd_data (outq_rd),
      .full    (outq_full),
      .empty   (rsp_empty),
      .count   (outq_count)
   );

   assign rsp_pixel_word = outq_rd.pixel_word;
   assign rsp_row_end    = outq_rd.row_end;
   assign rsp_image_end  = outq_rd.image_end;

   // The issue credit guarantees the queue never overflows.
   logic unused_full;
   assign unused_full = outq_full;

endmodule

@@ hdl/rgba_premultiply_converter_top.sv @@
// Top level of the RGBA to premultiplied 32-bit pixel converter.
// The block takes one source byte per clock cycle while req_full is low, padding
// bytes included, and gives one packed 32-bit pixel word per gathered pixel.
// A byte that completes a pixel shows up as a result on the rsp_ ports after
// passing through the front end, which writes the gathered pixel into a
// two-entry request queue, and the back end, which multiplies the colors by
// alpha in one registered stage and rounds and packs them on the way into a
// four-entry result queue. req_full rises only when the result side pops more
// slowly than pixels arrive and both queues back up. Registers must be written
// only while no request is in progress; the block itself does not enforce this.
module rgba_premultiply_converter_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_STRIDE = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [7:0]                         req_src_byte,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [31:0]                        rsp_pixel_word,
   output logic                               rsp_row_end,
   output logic                               rsp_image_end,
   input  logic                               csr_we,
   input  logic [rgbapm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbapm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int JCW = $clog2(rgbapm_pkg::JOB_DEPTH + 1);

   logic                 in_accept;
   logic                 job_valid;
   rgbapm_pkg::job_type  job_wr, job_rd;
   logic                 jobq_empty, jobq_pop;
   logic [JCW-1:0]       jobq_count;

   assign in_accept = req_push && !req_full;

   rgbapm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_STRIDE (MAX_STRIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_accept (in_accept),
      .in_byte   (req_src_byte),
      .job_valid (job_valid),
      .job       (job_wr)
   );

   rgbapm_fifo #(
      .WIDTH ($bits(rgbapm_pkg::job_type)),
      .DEPTH (rgbapm_pkg::JOB_DEPTH)
   ) u_jobq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_data (job_wr),
      .rd_en   (jobq_pop),
      .rd_data (job_rd),
      .full    (req_full),
      .empty   (jobq_empty),
      .count   (jobq_count)
   );

   rgbapm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (jobq_empty),
      .job            (job_rd),
      .job_pop        (jobq_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end)
   );

   // The fill level is only needed inside the back end for the result queue.
   logic unused_count;
   assign unused_count = ^jobq_count;

endmodule

@@ hdl/rgbapm_checker.sv @@
// Port-level checks for the converter, bound to the top level.
module rgbapm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_push,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic [31:0]                        rsp_pixel_word,
   input logic                               rsp_row_end,
   input logic                               rsp_image_end
);

   // Reset leaves both queues empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // The last pixel of the image is always the last pixel of its row.
   a_image_end_row_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_image_end) |-> rsp_row_end)
      else $error("image end without row end");

   // A result that is not popped stays on the ports unchanged.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_pixel_word) && $stable(rsp_row_end)
          && $stable(rsp_image_end)))
      else $error("waiting result changed");

   // A result can only appear after a request was taken.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && $past(rsp_empty) && $past(!(req_push && !req_full))
       && $past(!(req_push && !req_full), 2) && $past(rsp_empty, 2)
       && $past(rsp_empty, 3) && $past(!(req_push && !req_full), 3)) |=> rsp_empty)
      else $error("result without request");

endmodule

bind rgba_premultiply_converter_top rgbapm_checker u_rgbapm_checker (.*);
